@@ rtl/core/pressure_sensor_compensation_macros.svh @@
// Assertion macros for the pressure/temperature compensation pipeline
`ifndef PRESSURE_SENSOR_COMPENSATION_MACROS_SVH
`define PRESSURE_SENSOR_COMPENSATION_MACROS_SVH

// same-cycle implication, sampled on clk, off while in reset
`define PSC_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("pressure compensation check failed");

// next-cycle implication, sampled on clk, off while in reset
`define PSC_ASSERT_NXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("pressure compensation check failed");

`endif

@@ rtl/core/psc_pkg.sv @@
// Types and constants shared by the pressure/temperature compensation block
package psc_pkg;

	localparam int LATENCY = 10;

	typedef enum logic [2:0] {
		REG_PRESSURE_SENSITIVITY  = 3'd0,
		REG_PRESSURE_OFFSET       = 3'd1,
		REG_SENSITIVITY_TEMP_COEF = 3'd2,
		REG_OFFSET_TEMP_COEF      = 3'd3,
		REG_REFERENCE_TEMPERATURE = 3'd4,
		REG_TEMPERATURE_COEF      = 3'd5
	} cal_reg_t;

	typedef struct packed {
		logic [23:0] pressure_raw;
		logic [23:0] temperature_raw;
	} sample_t;

	typedef struct packed {
		logic signed [20:0] temperature_centi_c;
		logic signed [31:0] pressure_tenth_mbar;
		logic               calibration_invalid;
	} result_t;

	// 20.00 C and -15.00 C branch points, in hundredths
	localparam logic signed [19:0] T_NORMAL = 20'sd2000;
	localparam logic signed [20:0] T_VLOW_OFS = 21'sd1500;

	localparam logic signed [21:0] TEMP_MAX = 22'sd1048575;
	localparam logic signed [21:0] TEMP_MIN = -22'sd1048576;
	localparam logic signed [51:0] PRES_MAX = 52'sd2147483647;
	localparam logic signed [51:0] PRES_MIN = -52'sd2147483648;

	localparam logic [15:0] CAL_ALL_ONES = 16'hFFFF;

endpackage

@@ rtl/core/pressure_sensor_compensation.sv @@
// Second-order pressure/temperature compensation pipeline, top level
// Usage:
//   Input channel: a word of raw pressure and temperature conversions is taken
//   at a rising edge with start high and busy low.
//   Result channel: done is high for one cycle with the compensated word on
//   result; the receiver has no way to hold it off and must take it then.
//   Calibration: six 16-bit words written through cfg_we/cfg_index/cfg_data,
//   one per edge, only while no word is in flight; indexes above five are
//   ignored.
//   A word accepted at one edge is registered through stages s1 to s10 and is
//   taken from result at the rising edge that ends the cycle in which done is
//   high; a new word may be given every cycle, one word per cycle throughput,
//   through ten register stages of subtract, multiply, shift and saturate.
//   Reset clears the pipeline valids and calibration words; busy is high
//   during reset and until the first rising edge after release, low after.
//   Results are never stalled, so busy never rises again.
`include "pressure_sensor_compensation_macros.svh"

module pressure_sensor_compensation (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  psc_pkg::sample_t  sample,
	output logic              done,
	output psc_pkg::result_t  result,
	input  logic              cfg_we,
	input  logic [2:0]        cfg_index,
	input  logic [15:0]       cfg_data
);
	import psc_pkg::*;

	logic        busy_q;
	logic [15:0] c1_q, c2_q, c3_q, c4_q, c5_q, c6_q;
	logic        accept;
	logic        cal_bad;

	logic valid_s1, valid_s2, valid_s3, valid_s4, valid_s5;
	logic valid_s6, valid_s7, valid_s8, valid_s9, valid_s10;

	// stage payloads
	logic signed [25:0] diff_s1;
	logic [23:0]        d1_s1, d1_s2, d1_s3, d1_s4, d1_s5, d1_s6;
	logic signed [42:0] prod_t_s2, prod_s_s2, prod_o_s2;
	logic [49:0]        sq_s2;
	logic signed [19:0] t1_s3;
	logic signed [39:0] sens1_s3, sens1_s4, sens1_s5;
	logic signed [39:0] offs1_s3, offs1_s4, offs1_s5;
	logic [18:0]        tc_lo_s3, tc_hi_s3;
	logic [37:0]        dev_sq_s4, low_sq_s4;
	logic               lt_s4, vlow_s4;
	logic signed [20:0] tfin_s4, tfin_s5, tfin_s6, tfin_s7, tfin_s8, tfin_s9;
	logic [40:0]        ocorr_s5, scorr_s5;
	logic signed [43:0] sens_s6, offs_s6, offs_s7, offs_s8;
	logic [45:0]        p_lo_s7;
	logic signed [46:0] p_hi_s7;
	logic signed [69:0] full_s8;
	logic signed [51:0] r_s9;
	result_t            result_s10;

	// combinational next values
	logic signed [25:0] diff_n;
	logic signed [42:0] diff_x, c6_x, c3_x, c4_x;
	logic signed [51:0] diff_w, sq_w;
	logic signed [42:0] t_div, s_div, o_div;
	logic [51:0]        sq3;
	logic signed [20:0] t1_x, dev, low;
	logic signed [41:0] dev_sq_w, low_sq_w;
	logic               lt_n, vlow_n;
	logic [18:0]        tcorr;
	logic signed [21:0] tdiff;
	logic signed [20:0] tfin_n;
	logic [40:0]        dq, lq, ocorr_n, scorr_n;
	logic [21:0]        sens_lo;
	logic signed [21:0] sens_hi;
	logic signed [46:0] d1_x, hi_x;
	logic signed [69:0] q_w, r_w;
	logic signed [51:0] v_w;
	logic signed [31:0] pres_n;

	assign accept  = start && !busy_q;
	assign busy    = busy_q;
	assign done    = valid_s10;
	assign result  = result_s10;
	assign cal_bad = (c1_q == '0) || (c1_q == CAL_ALL_ONES);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b1;
			c1_q   <= '0;
			c2_q   <= '0;
			c3_q   <= '0;
			c4_q   <= '0;
			c5_q   <= '0;
			c6_q   <= '0;
		end else begin
			busy_q <= 1'b0;
			if (cfg_we) begin
				unique case (cal_reg_t'(cfg_index))
					REG_PRESSURE_SENSITIVITY:  c1_q <= cfg_data;
					REG_PRESSURE_OFFSET:       c2_q <= cfg_data;
					REG_SENSITIVITY_TEMP_COEF: c3_q <= cfg_data;
					REG_OFFSET_TEMP_COEF:      c4_q <= cfg_data;
					REG_REFERENCE_TEMPERATURE: c5_q <= cfg_data;
					REG_TEMPERATURE_COEF:      c6_q <= cfg_data;
					default: ;
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1  <= 1'b0;
			valid_s2  <= 1'b0;
			valid_s3  <= 1'b0;
			valid_s4  <= 1'b0;
			valid_s5  <= 1'b0;
			valid_s6  <= 1'b0;
			valid_s7  <= 1'b0;
			valid_s8  <= 1'b0;
			valid_s9  <= 1'b0;
			valid_s10 <= 1'b0;
		end else begin
			valid_s1  <= accept;
			valid_s2  <= valid_s1;
			valid_s3  <= valid_s2;
			valid_s4  <= valid_s3;
			valid_s5  <= valid_s4;
			valid_s6  <= valid_s5;
			valid_s7  <= valid_s6;
			valid_s8  <= valid_s7;
			valid_s9  <= valid_s8;
			valid_s10 <= valid_s9;
		end
	end

	always_comb begin
		// s1: temperature difference
		diff_n = $signed({2'b00, sample.temperature_raw}) - $signed({2'b00, c5_q, 8'h00});

		// s2: products on the difference
		diff_x = 43'(diff_s1);
		c6_x   = $signed({27'd0, c6_q});
		c3_x   = $signed({27'd0, c3_q});
		c4_x   = $signed({27'd0, c4_q});
		diff_w = 52'(diff_s1);
		sq_w   = diff_w * diff_w;

		// s3: truncating shifts, first-order terms
		t_div = (prod_t_s2 + (prod_t_s2[42] ? 43'sd8388607 : 43'sd0)) >>> 23;
		s_div = (prod_s_s2 + (prod_s_s2[42] ? 43'sd255 : 43'sd0)) >>> 8;
		o_div = (prod_o_s2 + (prod_o_s2[42] ? 43'sd127 : 43'sd0)) >>> 7;
		sq3   = {2'b00, sq_s2} + {1'b0, sq_s2, 1'b0};

		// s4: branch, squares, final temperature
		t1_x     = 21'(t1_s3);
		dev      = t1_x - 21'(T_NORMAL);
		low      = t1_x + T_VLOW_OFS;
		dev_sq_w = 42'(dev) * 42'(dev);
		low_sq_w = 42'(low) * 42'(low);
		lt_n     = t1_s3 < T_NORMAL;
		vlow_n   = low < 21'sd0;
		tcorr    = lt_n ? tc_lo_s3 : tc_hi_s3;
		tdiff    = 22'(t1_s3) - $signed({3'b000, tcorr});
		if (tdiff > TEMP_MAX) begin
			tfin_n = TEMP_MAX[20:0];
		end else if (tdiff < TEMP_MIN) begin
			tfin_n = TEMP_MIN[20:0];
		end else begin
			tfin_n = tdiff[20:0];
		end

		// s5: second-order corrections
		dq = 41'(dev_sq_s4);
		lq = 41'(low_sq_s4);
		if (lt_s4) begin
			ocorr_n = ((dq + (dq << 1)) >> 1) + (vlow_s4 ? ((lq << 3) - lq) : 41'd0);
			scorr_n = (((dq << 2) + dq) >> 3) + (vlow_s4 ? (lq << 2) : 41'd0);
		end else begin
			ocorr_n = dq >> 4;
			scorr_n = '0;
		end

		// s7: split product operands
		sens_lo = sens_s6[21:0];
		sens_hi = sens_s6[43:22];
		d1_x    = $signed({23'd0, d1_s6});
		hi_x    = 47'(sens_hi);

		// s9: scale product and remove offset
		q_w = (full_s8 + (full_s8[69] ? 70'sd2097151 : 70'sd0)) >>> 21;
		r_w = q_w - 70'(offs_s8);

		// s10: scale and saturate pressure
		v_w = (r_s9 + (r_s9[51] ? 52'sd8191 : 52'sd0)) >>> 13;
		if (v_w > PRES_MAX) begin
			pres_n = PRES_MAX[31:0];
		end else if (v_w < PRES_MIN) begin
			pres_n = PRES_MIN[31:0];
		end else begin
			pres_n = v_w[31:0];
		end
	end

	always_ff @(posedge clk) begin
		diff_s1 <= diff_n;
		d1_s1   <= sample.pressure_raw;

		prod_t_s2 <= diff_x * c6_x;
		prod_s_s2 <= diff_x * c3_x;
		prod_o_s2 <= diff_x * c4_x;
		sq_s2     <= sq_w[49:0];
		d1_s2     <= d1_s1;

		t1_s3    <= t_div[19:0] + T_NORMAL;
		sens1_s3 <= $signed({9'd0, c1_q, 15'd0}) + s_div[39:0];
		offs1_s3 <= $signed({8'd0, c2_q, 16'd0}) + o_div[39:0];
		tc_lo_s3 <= sq3[51:33];
		tc_hi_s3 <= {5'd0, sq_s2[49:36]};
		d1_s3    <= d1_s2;

		dev_sq_s4 <= dev_sq_w[37:0];
		low_sq_s4 <= low_sq_w[37:0];
		lt_s4     <= lt_n;
		vlow_s4   <= vlow_n;
		tfin_s4   <= tfin_n;
		sens1_s4  <= sens1_s3;
		offs1_s4  <= offs1_s3;
		d1_s4     <= d1_s3;

		ocorr_s5 <= ocorr_n;
		scorr_s5 <= scorr_n;
		sens1_s5 <= sens1_s4;
		offs1_s5 <= offs1_s4;
		tfin_s5  <= tfin_s4;
		d1_s5    <= d1_s4;

		sens_s6 <= 44'(sens1_s5) - 44'($signed({1'b0, scorr_s5}));
		offs_s6 <= 44'(offs1_s5) - 44'($signed({1'b0, ocorr_s5}));
		tfin_s6 <= tfin_s5;
		d1_s6   <= d1_s5;

		p_lo_s7 <= 46'(d1_s6) * 46'(sens_lo);
		p_hi_s7 <= d1_x * hi_x;
		offs_s7 <= offs_s6;
		tfin_s7 <= tfin_s6;

		full_s8 <= (70'(p_hi_s7) <<< 22) + 70'($signed({1'b0, p_lo_s7}));
		offs_s8 <= offs_s7;
		tfin_s8 <= tfin_s7;

		r_s9    <= r_w[51:0];
		tfin_s9 <= tfin_s8;

		result_s10.temperature_centi_c <= tfin_s9;
		result_s10.pressure_tenth_mbar <= pres_n;
		result_s10.calibration_invalid <= cal_bad;
	end

	`PSC_ASSERT_IMP(a_done_after_accept, done, $past(start && !busy, LATENCY))
	`PSC_ASSERT_IMP(a_flag_from_cal, done, result.calibration_invalid == $past(cal_bad))
	`PSC_ASSERT_NXT(a_busy_stays_low, !busy, !busy)

endmodule

@@ bench/tb_pressure_sensor_compensation.sv @@
// Self-checking bench for the pressure/temperature compensation pipeline
module tb_pressure_sensor_compensation;
	import psc_pkg::*;

	typedef logic [5:0][15:0] cal_set_t;

	localparam int          CYCLE_LIMIT   = 100000;
	localparam int          NUM_CAL       = 6;
	localparam longint      T_REF         = 2000;
	localparam longint      T_VLOW        = -1500;
	localparam longint      TCORR_LOW_DIV = 64'sd8589934592;
	localparam longint      TCORR_HI_DIV  = 64'sd137438953472;
	localparam logic [23:0] D_MAX         = 24'hFFFFFF;
	localparam logic [2:0]  IDX_SPARE_A   = 3'd6;
	localparam logic [2:0]  IDX_SPARE_B   = 3'd7;
	localparam cal_set_t    CAL_TYPICAL   = {16'd26146, 16'd26646, 16'd22354,
		16'd20328, 16'd36352, 16'd34982};
	localparam cal_set_t    CAL_ALL_ZERO  = '0;
	localparam cal_set_t    CAL_ALL_MAX   = '1;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        start;
	logic        busy;
	sample_t     sample_word;
	logic        done;
	result_t     result_word;
	logic        cfg_we;
	logic [2:0]  cfg_index;
	logic [15:0] cfg_data;

	cal_set_t    cal_word;
	sample_t     reading_queue [$];
	result_t     expected_results [$];
	int unsigned idle_pct;
	int unsigned mismatch_count;
	int unsigned cycle_count;
	logic        word_taken;

	pressure_sensor_compensation u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.sample    (sample_word),
		.done      (done),
		.result    (result_word),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	function automatic result_t compensate_reading(sample_t s);
		longint d1, d2, c1, c2, c3, c4, c5, c6;
		longint diff, t1, sens, offs, tcorr, ocorr, scorr, t_dev, t_vlow, tfin, pres;
		result_t r;
		d1 = s.pressure_raw;
		d2 = s.temperature_raw;
		c1 = cal_word[REG_PRESSURE_SENSITIVITY];
		c2 = cal_word[REG_PRESSURE_OFFSET];
		c3 = cal_word[REG_SENSITIVITY_TEMP_COEF];
		c4 = cal_word[REG_OFFSET_TEMP_COEF];
		c5 = cal_word[REG_REFERENCE_TEMPERATURE];
		c6 = cal_word[REG_TEMPERATURE_COEF];

		diff = d2 - c5 * 256;
		t1   = T_REF + (diff * c6) / 8388608;
		sens = c1 * 32768 + (c3 * diff) / 256;
		offs = c2 * 65536 + (c4 * diff) / 128;

		t_dev = t1 - T_REF;
		if (t1 < T_REF) begin
			tcorr = (3 * diff * diff) / TCORR_LOW_DIV;
			ocorr = (3 * t_dev * t_dev) / 2;
			scorr = (5 * t_dev * t_dev) / 8;
			if (t1 < T_VLOW) begin
				t_vlow = t1 - T_VLOW;
				ocorr  = ocorr + 7 * t_vlow * t_vlow;
				scorr  = scorr + 4 * t_vlow * t_vlow;
			end
		end else begin
			tcorr = (2 * diff * diff) / TCORR_HI_DIV;
			ocorr = (t_dev * t_dev) / 16;
			scorr = 0;
		end
		offs = offs - ocorr;
		sens = sens - scorr;

		tfin = t1 - tcorr;
		if (tfin < TEMP_MIN) tfin = TEMP_MIN;
		if (tfin > TEMP_MAX) tfin = TEMP_MAX;
		pres = ((d1 * sens) / 2097152 - offs) / 8192;
		if (pres < PRES_MIN) pres = PRES_MIN;
		if (pres > PRES_MAX) pres = PRES_MAX;

		r.temperature_centi_c = tfin[20:0];
		r.pressure_tenth_mbar = pres[31:0];
		r.calibration_invalid = (cal_word[REG_PRESSURE_SENSITIVITY] == 16'h0000) ||
			(cal_word[REG_PRESSURE_SENSITIVITY] == CAL_ALL_ONES);
		return r;
	endfunction

	// raw temperature that lands first-order temperature just past the target
	function automatic logic [23:0] temperature_reading_for(longint target);
		longint diff, d2;
		diff = 0;
		if (cal_word[REG_TEMPERATURE_COEF] != 16'h0000) begin
			diff = ((target - T_REF) * 8388608) / longint'(cal_word[REG_TEMPERATURE_COEF]);
			if (target < T_REF) diff = diff - 1;
			else if (target > T_REF) diff = diff + 1;
		end
		d2 = longint'(cal_word[REG_REFERENCE_TEMPERATURE]) * 256 + diff;
		if (d2 < 0) d2 = 0;
		if (d2 > longint'(D_MAX)) d2 = D_MAX;
		return d2[23:0];
	endfunction

	task automatic queue_reading(input logic [23:0] p_raw, input logic [23:0] t_raw);
		sample_t item;
		item.pressure_raw    = p_raw;
		item.temperature_raw = t_raw;
		reading_queue.push_back(item);
	endtask

	task automatic queue_random_reading();
		logic [23:0] p_raw, t_raw;
		longint target;
		if ($urandom_range(0, 9) < 8) p_raw = 24'($urandom);
		else p_raw = $urandom_range(0, 1) ? D_MAX : 24'h000000;
		if ($urandom_range(0, 4) < 2) begin
			t_raw = 24'($urandom);
		end else begin
			if ($urandom_range(0, 3) == 0)
				target = ($urandom_range(0, 1) ? T_REF : T_VLOW) +
					longint'($urandom_range(0, 4)) - 2;
			else
				target = longint'($urandom_range(0, 12500)) - 4000;
			t_raw = temperature_reading_for(target);
		end
		queue_reading(p_raw, t_raw);
	endtask

	task automatic load_calibration(input cal_set_t words);
		int i;
		for (i = 0; i < NUM_CAL; i++) begin
			@(negedge clk);
			cfg_we    <= 1'b1;
			cfg_index <= i[2:0];
			cfg_data  <= words[i];
			@(posedge clk);
			cal_word[i] = words[i];
		end
		// spare indexes must be ignored
		if ($urandom_range(0, 1)) begin
			@(negedge clk);
			cfg_index <= $urandom_range(0, 1) ? IDX_SPARE_A : IDX_SPARE_B;
			cfg_data  <= 16'($urandom);
			@(posedge clk);
		end
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic pick_calibration(output cal_set_t words);
		int i;
		case ($urandom_range(0, 4))
			0, 1: begin
				for (i = 0; i < NUM_CAL; i++) words[i] = 16'($urandom);
			end
			2: begin
				for (i = 0; i < NUM_CAL; i++)
					words[i] = CAL_TYPICAL[i] + 16'($urandom_range(0, 4095)) - 16'd2048;
			end
			3: begin
				for (i = 0; i < NUM_CAL; i++)
					case ($urandom_range(0, 2))
						0:       words[i] = 16'h0000;
						1:       words[i] = CAL_ALL_ONES;
						default: words[i] = 16'($urandom);
					endcase
			end
			default: begin
				words = CAL_TYPICAL;
				words[REG_PRESSURE_SENSITIVITY] = $urandom_range(0, 1) ? CAL_ALL_ONES : 16'h0000;
			end
		endcase
	endtask

	task automatic wait_idle();
		while (reading_queue.size() != 0 || start || expected_results.size() != 0)
			@(posedge clk);
	endtask

	always @(posedge clk) begin : cycle_guard
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	always @(negedge clk) begin : drive_words
		if (arst_n && (!start || word_taken)) begin
			if (reading_queue.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
				start       <= 1'b1;
				sample_word <= reading_queue.pop_front();
			end else begin
				start <= 1'b0;
			end
		end
		word_taken = 1'b0;
	end

	always @(posedge clk) begin : check_results
		result_t want;
		if (arst_n) begin
			if (done) begin
				if (expected_results.size() == 0) begin
					$error("result word with nothing expected");
					mismatch_count++;
				end else begin
					want = expected_results.pop_front();
					if (result_word.temperature_centi_c !== want.temperature_centi_c) begin
						$error("temperature_centi_c expected %0d got %0d",
							want.temperature_centi_c, result_word.temperature_centi_c);
						mismatch_count++;
					end
					if (result_word.pressure_tenth_mbar !== want.pressure_tenth_mbar) begin
						$error("pressure_tenth_mbar expected %0d got %0d",
							want.pressure_tenth_mbar, result_word.pressure_tenth_mbar);
						mismatch_count++;
					end
					if (result_word.calibration_invalid !== want.calibration_invalid) begin
						$error("calibration_invalid expected %0b got %0b",
							want.calibration_invalid, result_word.calibration_invalid);
						mismatch_count++;
					end
				end
			end
			if (start && !busy) begin
				expected_results.push_back(compensate_reading(sample_word));
				word_taken = 1'b1;
			end
		end
	end

	initial begin : stimulus
		cal_set_t words;
		int regime, phase;
		arst_n         = 1'b0;
		start          = 1'b0;
		sample_word    = '0;
		cfg_we         = 1'b0;
		cfg_index      = REG_PRESSURE_SENSITIVITY;
		cfg_data       = 16'h0000;
		cal_word       = CAL_ALL_ZERO;
		idle_pct       = 10;
		mismatch_count = 0;
		cycle_count    = 0;
		word_taken     = 1'b0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed: field extremes and branch edges on typical calibration
		load_calibration(CAL_TYPICAL);
		queue_reading(24'h000000, 24'h000000);
		queue_reading(D_MAX, D_MAX);
		queue_reading(24'h000000, D_MAX);
		queue_reading(D_MAX, 24'h000000);
		queue_reading(24'h800000, temperature_reading_for(T_REF));
		queue_reading(24'h800000, temperature_reading_for(T_REF - 1));
		queue_reading(24'h800000, temperature_reading_for(T_REF + 1));
		queue_reading(D_MAX, temperature_reading_for(T_VLOW + 1));
		queue_reading(D_MAX, temperature_reading_for(T_VLOW));
		queue_reading(D_MAX, temperature_reading_for(T_VLOW - 1));
		queue_reading(D_MAX, temperature_reading_for(-4000));
		queue_reading(24'($urandom), temperature_reading_for(8500));
		wait_idle();

		// invalid sensitivity word, both flavours
		words = CAL_TYPICAL;
		words[REG_PRESSURE_SENSITIVITY] = 16'h0000;
		load_calibration(words);
		queue_reading(D_MAX, temperature_reading_for(T_REF));
		queue_reading(24'($urandom), temperature_reading_for(-2000));
		queue_reading(24'h000000, D_MAX);
		wait_idle();
		words[REG_PRESSURE_SENSITIVITY] = CAL_ALL_ONES;
		load_calibration(words);
		queue_reading(D_MAX, temperature_reading_for(T_REF));
		queue_reading(24'($urandom), temperature_reading_for(-2000));
		queue_reading(24'h000000, D_MAX);
		wait_idle();

		load_calibration(CAL_ALL_ZERO);
		queue_reading(D_MAX, D_MAX);
		queue_reading(24'h000000, 24'h000000);
		queue_reading(D_MAX, 24'h000000);
		wait_idle();

		load_calibration(CAL_ALL_MAX);
		queue_reading(D_MAX, D_MAX);
		queue_reading(D_MAX, 24'h000000);
		queue_reading(24'h000000, 24'h000000);
		queue_reading(24'h800000, temperature_reading_for(T_VLOW - 1));
		wait_idle();

		// random: light idling, heavy idling, then back to back
		for (regime = 0; regime < 3; regime++) begin
			idle_pct = (regime == 0) ? 10 : (regime == 1) ? 55 : 0;
			for (phase = 0; phase < 4; phase++) begin
				pick_calibration(words);
				load_calibration(words);
				repeat (102) queue_random_reading();
				wait_idle();
			end
		end

		repeat (LATENCY + 4) @(posedge clk);
		if (mismatch_count == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
